FILE: rtl/tamper_alarm_tick_controller_top_defines.svh
// Assertion helpers shared by the tamper alarm tick controller RTL.
// Every property is sampled on i_clk and disabled while i_rst_n is low.
`ifndef TAMPER_ALARM_TICK_CONTROLLER_TOP_DEFINES_SVH
`define TAMPER_ALARM_TICK_CONTROLLER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tac_pkg.sv
package tac_pkg;

    // Field widths
    localparam int unsigned TICKS_W    = 12;
    localparam int unsigned WIRE_W     = 6;
    localparam int unsigned BATTERY_W  = 10;
    localparam int unsigned MSG_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_HOLD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIRE_CUT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_HIGH  = 3'd5;

    // Register reset values
    localparam logic [TICKS_W-1:0]   RST_SLOW_PERIOD   = 12'd2000;
    localparam logic [TICKS_W-1:0]   RST_STAGE_TIMEOUT = 12'd4000;
    localparam logic [TICKS_W-1:0]   RST_TILT_HOLD     = 12'd4000;
    localparam logic [WIRE_W-1:0]    RST_WIRE_CUT      = 6'd50;
    localparam logic [BATTERY_W-1:0] RST_BATTERY_LOW   = 10'h100;
    localparam logic [BATTERY_W-1:0] RST_BATTERY_HIGH  = 10'h200;

    // Theft message codes
    localparam logic [MSG_W-1:0] MSG_NONE     = 2'd0;
    localparam logic [MSG_W-1:0] MSG_TAMPER   = 2'd1;
    localparam logic [MSG_W-1:0] MSG_CUT_WIRE = 2'd2;

    // Burst and debounce limits
    localparam logic [2:0] TILT_ALARM_MAX    = 3'd5;
    localparam logic [2:0] BATTERY_ALARM_MAX = 3'd4;
    localparam logic [1:0] THEFT_BURST_LAST  = 2'd3;
    localparam logic [WIRE_W-1:0] WIRE_COUNT_MAX = 6'h3F;
    localparam logic [3:0] DEBOUNCE_HIT      = 4'd3;
    localparam logic [3:0] DEBOUNCE_HOLD     = 4'd11;

    typedef struct packed {
        logic [TICKS_W-1:0]   slow_period;
        logic [TICKS_W-1:0]   stage_timeout;
        logic [TICKS_W-1:0]   tilt_hold;
        logic [WIRE_W-1:0]    wire_cut;
        logic [BATTERY_W-1:0] battery_low;
        logic [BATTERY_W-1:0] battery_high;
    } t_cfg;

    typedef struct packed {
        logic                 touch_active;
        logic                 raised_line_low;
        logic                 fell_line_low;
        logic                 wire_intact;
        logic [BATTERY_W-1:0] battery_level;
        logic                 sensor_enable;
        logic                 position_enable;
        logic                 key_on;
    } t_in_item;

    typedef struct packed {
        logic             first_touch_event;
        logic             second_touch_event;
        logic [MSG_W-1:0] theft_message;
        logic             theft_speech_one;
        logic             theft_speech_two;
        logic             battery_alarm;
        logic             raised_alarm;
        logic             fell_alarm;
        logic             raised_state;
        logic             fell_state;
        logic             theft_active;
    } t_out_item;

endpackage

FILE: rtl/tac_cfg.sv
module tac_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tac_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output tac_pkg::t_cfg                      o_cfg
);

    tac_pkg::t_cfg r_cfg;

    // Hold the register file, write one register per enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_period   <= tac_pkg::RST_SLOW_PERIOD;
            r_cfg.stage_timeout <= tac_pkg::RST_STAGE_TIMEOUT;
            r_cfg.tilt_hold     <= tac_pkg::RST_TILT_HOLD;
            r_cfg.wire_cut      <= tac_pkg::RST_WIRE_CUT;
            r_cfg.battery_low   <= tac_pkg::RST_BATTERY_LOW;
            r_cfg.battery_high  <= tac_pkg::RST_BATTERY_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tac_pkg::REG_SLOW_PERIOD:   r_cfg.slow_period   <= i_cfg_data;
                tac_pkg::REG_STAGE_TIMEOUT: r_cfg.stage_timeout <= i_cfg_data;
                tac_pkg::REG_TILT_HOLD:     r_cfg.tilt_hold     <= i_cfg_data;
                tac_pkg::REG_WIRE_CUT:
                    r_cfg.wire_cut <= i_cfg_data[tac_pkg::WIRE_W-1:0];
                tac_pkg::REG_BATTERY_LOW:
                    r_cfg.battery_low <= i_cfg_data[tac_pkg::BATTERY_W-1:0];
                tac_pkg::REG_BATTERY_HIGH:
                    r_cfg.battery_high <= i_cfg_data[tac_pkg::BATTERY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/tac_core.sv
`include "tamper_alarm_tick_controller_top_defines.svh"

module tac_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tac_pkg::t_cfg       i_cfg,
    input  logic                i_fire,
    input  tac_pkg::t_in_item   i_item,
    output tac_pkg::t_out_item  o_result
);

    typedef enum logic [1:0] {
        ST_WAIT_FIRST,
        ST_WAIT_SECOND,
        ST_ARMED
    } t_stage;

    // State registers
    t_stage                             r_stage, n_stage;
    logic [tac_pkg::TICKS_W-1:0]        r_slow_count, n_slow_count;
    logic [tac_pkg::BATTERY_W-1:0]      r_battery_latch, n_battery_latch;
    logic                               r_first_count, n_first_count;
    logic                               r_second_count, n_second_count;
    logic [tac_pkg::TICKS_W-1:0]        r_second_time, n_second_time;
    logic [tac_pkg::TICKS_W-1:0]        r_third_time, n_third_time;
    logic                               r_alarm_one_en, n_alarm_one_en;
    logic                               r_alarm_two_en, n_alarm_two_en;
    logic [1:0]                         r_alarm_one_count, n_alarm_one_count;
    logic [1:0]                         r_alarm_two_count, n_alarm_two_count;
    logic                               r_theft_busy, n_theft_busy;
    logic                               r_third_alarm, n_third_alarm;
    logic [tac_pkg::WIRE_W-1:0]         r_wire_low, n_wire_low;
    logic                               r_wire_cut, n_wire_cut;
    logic                               r_battery_removed, n_battery_removed;
    logic [2:0]                         r_battery_count, n_battery_count;
    logic [3:0]                         r_raise_deb, n_raise_deb;
    logic [3:0]                         r_fall_deb, n_fall_deb;
    logic                               r_raised, n_raised;
    logic                               r_fell, n_fell;
    logic [2:0]                         r_raised_count, n_raised_count;
    logic [2:0]                         r_fell_count, n_fell_count;
    logic                               r_tilt_event, n_tilt_event;
    logic [tac_pkg::TICKS_W-1:0]        r_tilt_hold, n_tilt_hold;
    logic                               r_tilt_seen, n_tilt_seen;

    // Per-item pulses
    logic                               w_ev1, w_ev2, w_sp1, w_sp2;
    logic                               w_bat_al, w_rai_al, w_fel_al;
    logic [tac_pkg::MSG_W-1:0]          w_msg;
    logic                               w_upright;
    logic [tac_pkg::WIRE_W-1:0]         w_wire_limit;

    assign w_upright = !i_item.raised_line_low && !i_item.fell_line_low
                       && i_item.sensor_enable;
    // Cut-wire limit is the threshold plus one, saturated at the counter max
    assign w_wire_limit = (i_cfg.wire_cut == tac_pkg::WIRE_COUNT_MAX)
                          ? tac_pkg::WIRE_COUNT_MAX : i_cfg.wire_cut + 6'd1;

    // Advance all state for one tick
    always_comb begin
        n_stage           = r_stage;
        n_slow_count      = r_slow_count + 12'd1;
        n_battery_latch   = r_battery_latch;
        n_first_count     = r_first_count;
        n_second_count    = r_second_count;
        n_second_time     = r_second_time;
        n_third_time      = r_third_time;
        n_alarm_one_en    = r_alarm_one_en;
        n_alarm_two_en    = r_alarm_two_en;
        n_alarm_one_count = r_alarm_one_count;
        n_alarm_two_count = r_alarm_two_count;
        n_theft_busy      = r_theft_busy;
        n_third_alarm     = r_third_alarm;
        n_wire_low        = r_wire_low;
        n_wire_cut        = r_wire_cut;
        n_battery_removed = r_battery_removed;
        n_battery_count   = r_battery_count;
        n_raise_deb       = r_raise_deb;
        n_fall_deb        = r_fall_deb;
        n_raised          = r_raised;
        n_fell            = r_fell;
        n_raised_count    = r_raised_count;
        n_fell_count      = r_fell_count;
        n_tilt_event      = r_tilt_event;
        n_tilt_hold       = r_tilt_hold;
        n_tilt_seen       = r_tilt_seen;
        w_ev1    = 1'b0;
        w_ev2    = 1'b0;
        w_sp1    = 1'b0;
        w_sp2    = 1'b0;
        w_bat_al = 1'b0;
        w_rai_al = 1'b0;
        w_fel_al = 1'b0;
        w_msg    = tac_pkg::MSG_NONE;

        // Slow tick: latch battery and send alarm bursts
        if (n_slow_count >= i_cfg.slow_period) begin
            n_slow_count    = '0;
            n_battery_latch = i_item.battery_level;
            if (r_fell && r_fell_count < tac_pkg::TILT_ALARM_MAX) begin
                w_fel_al     = 1'b1;
                n_fell_count = r_fell_count + 3'd1;
            end
            if (r_raised && r_raised_count < tac_pkg::TILT_ALARM_MAX) begin
                w_rai_al       = 1'b1;
                n_raised_count = r_raised_count + 3'd1;
            end
            if (r_battery_removed && r_battery_count < tac_pkg::BATTERY_ALARM_MAX
                && !i_item.key_on) begin
                w_bat_al        = 1'b1;
                n_battery_count = r_battery_count + 3'd1;
            end
            if (r_alarm_one_en) begin
                n_theft_busy = 1'b1;
                if (!i_item.key_on) begin
                    w_msg = r_wire_cut ? tac_pkg::MSG_CUT_WIRE : tac_pkg::MSG_TAMPER;
                    w_sp1 = 1'b1;
                end
                if (r_alarm_one_count == tac_pkg::THEFT_BURST_LAST) begin
                    n_alarm_one_count = '0;
                    n_alarm_one_en    = 1'b0;
                    n_theft_busy      = 1'b0;
                    n_third_alarm     = 1'b0;
                end else begin
                    n_alarm_one_count = r_alarm_one_count + 2'd1;
                end
            end
            if (r_alarm_two_en) begin
                n_theft_busy = 1'b1;
                if (!i_item.key_on) begin
                    w_msg = r_wire_cut ? tac_pkg::MSG_CUT_WIRE : tac_pkg::MSG_TAMPER;
                    w_sp2 = 1'b1;
                end
                if (r_alarm_two_count == tac_pkg::THEFT_BURST_LAST) begin
                    n_alarm_two_count = '0;
                    n_alarm_two_en    = 1'b0;
                    n_theft_busy      = 1'b0;
                    n_third_alarm     = 1'b0;
                end else begin
                    n_alarm_two_count = r_alarm_two_count + 2'd1;
                end
            end
        end

        // Touch stages, wire and battery checks while upright and the sensor is enabled
        if (w_upright) begin
            case (r_stage)
                ST_WAIT_FIRST: begin
                    if (i_item.touch_active && !n_theft_busy) begin
                        if (r_first_count) begin
                            n_first_count = 1'b0;
                            n_stage       = ST_WAIT_SECOND;
                            w_ev1         = 1'b1;
                        end else begin
                            n_first_count = 1'b1;
                        end
                    end else begin
                        n_first_count = 1'b0;
                    end
                end
                ST_WAIT_SECOND: begin
                    if (i_item.touch_active) begin
                        if (r_second_count) begin
                            n_second_count = 1'b0;
                            n_stage        = ST_ARMED;
                            w_ev2          = 1'b1;
                        end else begin
                            n_second_count = 1'b1;
                        end
                    end else begin
                        n_second_count = 1'b0;
                    end
                    n_second_time = r_second_time + 12'd1;
                    if (n_second_time >= i_cfg.stage_timeout) begin
                        n_stage        = ST_WAIT_FIRST;
                        n_second_count = 1'b0;
                        n_first_count  = 1'b0;
                        n_second_time  = '0;
                    end
                end
                ST_ARMED: begin
                    if (i_item.touch_active) begin
                        n_alarm_one_en = 1'b1;
                        n_alarm_two_en = 1'b1;
                        n_third_alarm  = 1'b1;
                    end
                    n_third_time = r_third_time + 12'd1;
                    if (n_third_time >= i_cfg.stage_timeout) begin
                        n_stage        = ST_WAIT_FIRST;
                        n_first_count  = 1'b0;
                        n_second_count = 1'b0;
                        n_second_time  = '0;
                        n_third_time   = '0;
                    end
                end
                default: begin
                end
            endcase

            // Count low-wire ticks, declare cut past the threshold
            if (!i_item.wire_intact && r_wire_low < w_wire_limit) begin
                n_wire_low = r_wire_low + 6'd1;
                if (n_wire_low > i_cfg.wire_cut) begin
                    n_alarm_one_en = 1'b1;
                    n_alarm_two_en = 1'b1;
                    n_wire_cut     = 1'b1;
                end
            end else if (i_item.wire_intact && !n_third_alarm) begin
                n_wire_low     = '0;
                n_alarm_one_en = 1'b0;
                n_alarm_two_en = 1'b0;
            end

            // Battery removal with hysteresis
            if (n_battery_latch < i_cfg.battery_low) begin
                n_battery_removed = 1'b1;
            end else if (n_battery_latch > i_cfg.battery_high) begin
                n_battery_removed = 1'b0;
                n_battery_count   = '0;
            end
        end

        // Debounce raise and fall lines
        if (i_item.position_enable) begin
            if (i_item.raised_line_low) begin
                n_raise_deb = r_raise_deb + 4'd1;
                if (n_raise_deb >= tac_pkg::DEBOUNCE_HIT) begin
                    n_raised    = 1'b1;
                    n_fell      = 1'b0;
                    n_raise_deb = tac_pkg::DEBOUNCE_HOLD;
                    if (!r_tilt_seen) n_tilt_event = 1'b1;
                end
            end else begin
                n_raised       = 1'b0;
                n_raised_count = '0;
                n_raise_deb    = '0;
                n_tilt_event   = 1'b0;
            end
            if (i_item.fell_line_low) begin
                n_fall_deb = r_fall_deb + 4'd1;
                if (n_fall_deb >= tac_pkg::DEBOUNCE_HIT) begin
                    n_fell       = 1'b1;
                    n_raised     = 1'b0;
                    n_fall_deb   = tac_pkg::DEBOUNCE_HOLD;
                    if (!r_tilt_seen) n_tilt_event = 1'b1;
                end
            end else begin
                n_fell       = 1'b0;
                n_fell_count = '0;
                n_fall_deb   = '0;
                n_tilt_event = 1'b0;
            end
        end

        // Hold after the first tilt, then reset the touch stages
        if (n_tilt_event) begin
            n_tilt_hold = r_tilt_hold + 12'd1;
            if (n_tilt_hold >= i_cfg.tilt_hold) begin
                n_tilt_event   = 1'b0;
                n_tilt_hold    = '0;
                n_tilt_seen    = 1'b1;
                n_stage        = ST_WAIT_FIRST;
                n_first_count  = 1'b0;
                n_second_count = 1'b0;
                n_second_time  = '0;
                n_third_time   = '0;
            end
        end
    end

    // Hold state; advance it on each fired item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage           <= ST_WAIT_FIRST;
            r_slow_count      <= '0;
            r_battery_latch   <= '0;
            r_first_count     <= 1'b0;
            r_second_count    <= 1'b0;
            r_second_time     <= '0;
            r_third_time      <= '0;
            r_alarm_one_en    <= 1'b0;
            r_alarm_two_en    <= 1'b0;
            r_alarm_one_count <= '0;
            r_alarm_two_count <= '0;
            r_theft_busy      <= 1'b0;
            r_third_alarm     <= 1'b0;
            r_wire_low        <= '0;
            r_wire_cut        <= 1'b0;
            r_battery_removed <= 1'b0;
            r_battery_count   <= '0;
            r_raise_deb       <= '0;
            r_fall_deb        <= '0;
            r_raised          <= 1'b0;
            r_fell            <= 1'b0;
            r_raised_count    <= '0;
            r_fell_count      <= '0;
            r_tilt_event      <= 1'b0;
            r_tilt_hold       <= '0;
            r_tilt_seen       <= 1'b0;
        end else if (i_fire) begin
            r_stage           <= n_stage;
            r_slow_count      <= n_slow_count;
            r_battery_latch   <= n_battery_latch;
            r_first_count     <= n_first_count;
            r_second_count    <= n_second_count;
            r_second_time     <= n_second_time;
            r_third_time      <= n_third_time;
            r_alarm_one_en    <= n_alarm_one_en;
            r_alarm_two_en    <= n_alarm_two_en;
            r_alarm_one_count <= n_alarm_one_count;
            r_alarm_two_count <= n_alarm_two_count;
            r_theft_busy      <= n_theft_busy;
            r_third_alarm     <= n_third_alarm;
            r_wire_low        <= n_wire_low;
            r_wire_cut        <= n_wire_cut;
            r_battery_removed <= n_battery_removed;
            r_battery_count   <= n_battery_count;
            r_raise_deb       <= n_raise_deb;
            r_fall_deb        <= n_fall_deb;
            r_raised          <= n_raised;
            r_fell            <= n_fell;
            r_raised_count    <= n_raised_count;
            r_fell_count      <= n_fell_count;
            r_tilt_event      <= n_tilt_event;
            r_tilt_hold       <= n_tilt_hold;
            r_tilt_seen       <= n_tilt_seen;
        end
    end

    // Pack the result for this tick
    always_comb begin
        o_result.first_touch_event  = w_ev1;
        o_result.second_touch_event = w_ev2;
        o_result.theft_message      = w_msg;
        o_result.theft_speech_one   = w_sp1;
        o_result.theft_speech_two   = w_sp2;
        o_result.battery_alarm      = w_bat_al;
        o_result.raised_alarm       = w_rai_al;
        o_result.fell_alarm         = w_fel_al;
        o_result.raised_state       = n_raised;
        o_result.fell_state         = n_fell;
        o_result.theft_active       = n_theft_busy;
    end

    // Checks
    `TAC_ASSERT_NEXT(a_tilt_seen_sticky, r_tilt_seen, r_tilt_seen, "tilt seen flag cleared")
    `TAC_ASSERT_NEXT(a_wire_cut_sticky, r_wire_cut, r_wire_cut, "cut wire flag cleared")

endmodule

FILE: rtl/tamper_alarm_tick_controller_top.sv
// Tamper alarm tick controller, one input item per 1 ms tick, one result item per tick.
// Path: an accepted item passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle while the result side is ready; while a result waits, one more item is held.
// Reset: synchronous, active low on i_rst_n; clears all counters and flags and
// loads the register file with its default values. No clearing pass is needed.
`include "tamper_alarm_tick_controller_top_defines.svh"

module tamper_alarm_tick_controller_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // [0] touch_active, [1] raised_line_low, [2] fell_line_low, [3] wire_intact,
    // [13:4] battery_level, [14] sensor_enable, [15] position_enable, [16] key_on,
    // [23:17] zero
    input  logic [tac_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [0] first_touch_event, [1] second_touch_event, [3:2] theft_message,
    // [4] theft_speech_one, [5] theft_speech_two, [6] battery_alarm,
    // [7] raised_alarm, [8] fell_alarm, [9] raised_state, [10] fell_state,
    // [11] theft_active, [15:12] zero
    output logic [tac_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic                               i_cfg_we,
    input  logic [tac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tac_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                              r_in_valid;
    logic [tac_pkg::IN_DATA_W-1:0]     r_in_data;
    logic                              r_out_valid;
    tac_pkg::t_out_item                r_out_item;
    logic                              w_fire;
    tac_pkg::t_cfg                     w_cfg;
    tac_pkg::t_in_item                 w_item;
    tac_pkg::t_out_item                w_result;

    // Move an item into the result register when it is empty or being drained
    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    // Unpack the staged item
    assign w_item.touch_active    = r_in_data[0];
    assign w_item.raised_line_low = r_in_data[1];
    assign w_item.fell_line_low   = r_in_data[2];
    assign w_item.wire_intact     = r_in_data[3];
    assign w_item.battery_level   = r_in_data[13:4];
    assign w_item.sensor_enable   = r_in_data[14];
    assign w_item.position_enable = r_in_data[15];
    assign w_item.key_on          = r_in_data[16];

    tac_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tac_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .o_result (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    // Pack the result item
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0,
                              r_out_item.theft_active,
                              r_out_item.fell_state,
                              r_out_item.raised_state,
                              r_out_item.fell_alarm,
                              r_out_item.raised_alarm,
                              r_out_item.battery_alarm,
                              r_out_item.theft_speech_two,
                              r_out_item.theft_speech_one,
                              r_out_item.theft_message,
                              r_out_item.second_touch_event,
                              r_out_item.first_touch_event};

    // Checks
    `TAC_ASSERT_NOW(a_msg_code_valid, r_out_valid, r_out_item.theft_message <= tac_pkg::MSG_CUT_WIRE, "bad theft message code")
    `TAC_ASSERT_NOW(a_speech_has_msg, r_out_valid && (r_out_item.theft_speech_one || r_out_item.theft_speech_two), r_out_item.theft_message != tac_pkg::MSG_NONE, "speech without message")
    `TAC_ASSERT_NOW(a_tilt_exclusive, r_out_valid, !(r_out_item.raised_state && r_out_item.fell_state), "raised and fell both set")

endmodule

FILE: tb/sv/tac_tick_checker.sv
module tac_tick_checker
    import tac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatch_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] BURST_LEN = 3'd4;

    typedef enum logic [1:0] {
        STAGE_FIRST  = 2'd0,
        STAGE_SECOND = 2'd1,
        STAGE_THIRD  = 2'd2,
        STAGE_UNUSED = 2'd3
    } t_touch_stage;

    // Register copy
    logic [TICKS_W-1:0]   cfg_slow;
    logic [TICKS_W-1:0]   cfg_stage;
    logic [TICKS_W-1:0]   cfg_tilt;
    logic [WIRE_W-1:0]    cfg_wire;
    logic [BATTERY_W-1:0] cfg_bat_low;
    logic [BATTERY_W-1:0] cfg_bat_high;

    // Tick state
    logic [TICKS_W-1:0]   slow_count;
    logic [BATTERY_W-1:0] battery_seen;
    t_touch_stage         touch_phase;
    logic [1:0]           first_hits;
    logic [1:0]           second_hits;
    logic                 third_hits;
    logic [TICKS_W-1:0]   second_wait;
    logic [TICKS_W-1:0]   third_wait;
    logic                 burst_one_armed;
    logic                 burst_two_armed;
    logic [2:0]           burst_one_sent;
    logic [2:0]           burst_two_sent;
    logic                 theft_on;
    logic                 touch_alarm_latched;
    logic [WIRE_W-1:0]    wire_low_run;
    logic                 wire_cut_seen;
    logic                 battery_gone;
    logic [2:0]           battery_alarms_sent;
    logic [7:0]           raise_filter;
    logic [7:0]           fall_filter;
    logic                 raised_now;
    logic                 fell_now;
    logic [2:0]           raised_alarms_sent;
    logic [2:0]           fell_alarms_sent;
    logic                 tilt_pending;
    logic [TICKS_W-1:0]   tilt_wait;
    logic                 tilt_done;

    t_out_item expected_ticks[$];
    int        mismatch_total;
    int        results_seen;

    assign o_mismatch_count = mismatch_total;

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
        mismatch_total++;
    endtask

    function automatic void clear_touch_stages();
        touch_phase = STAGE_FIRST;
        first_hits  = '0;
        second_hits = '0;
        third_hits  = 1'b0;
        second_wait = '0;
        third_wait  = '0;
    endfunction

    // Advance the tick state by one item and return the result it causes
    function automatic t_out_item predict_tick(input t_in_item it);
        t_out_item   r;
        int unsigned wire_limit;
        r = '0;

        // Slow tick: latch battery, send limited alarm bursts
        slow_count = slow_count + 1'b1;
        if (slow_count >= cfg_slow) begin
            slow_count   = '0;
            battery_seen = it.battery_level;
            if (fell_now && fell_alarms_sent < TILT_ALARM_MAX) begin
                r.fell_alarm = 1'b1;
                fell_alarms_sent++;
            end
            if (raised_now && raised_alarms_sent < TILT_ALARM_MAX) begin
                r.raised_alarm = 1'b1;
                raised_alarms_sent++;
            end
            if (battery_gone && battery_alarms_sent < BATTERY_ALARM_MAX && !it.key_on) begin
                r.battery_alarm = 1'b1;
                battery_alarms_sent++;
            end
            if (burst_one_armed && burst_one_sent < BURST_LEN) begin
                theft_on = 1'b1;
                if (!it.key_on) begin
                    r.theft_message    = wire_cut_seen ? MSG_CUT_WIRE : MSG_TAMPER;
                    r.theft_speech_one = 1'b1;
                end
                burst_one_sent++;
                if (burst_one_sent >= BURST_LEN) begin
                    burst_one_sent      = '0;
                    burst_one_armed     = 1'b0;
                    theft_on            = 1'b0;
                    touch_alarm_latched = 1'b0;
                end
            end
            if (burst_two_armed && burst_two_sent < BURST_LEN) begin
                theft_on = 1'b1;
                if (!it.key_on) begin
                    r.theft_message    = wire_cut_seen ? MSG_CUT_WIRE : MSG_TAMPER;
                    r.theft_speech_two = 1'b1;
                end
                burst_two_sent++;
                if (burst_two_sent >= BURST_LEN) begin
                    burst_two_sent      = '0;
                    burst_two_armed     = 1'b0;
                    theft_on            = 1'b0;
                    touch_alarm_latched = 1'b0;
                end
            end
        end

        // Touch, wire and battery checks only while upright and enabled
        if (!it.raised_line_low && !it.fell_line_low && it.sensor_enable) begin
            case (touch_phase)
                STAGE_FIRST: begin
                    if (it.touch_active && !theft_on) begin
                        first_hits++;
                        if (first_hits >= 2'd2) begin
                            first_hits          = '0;
                            touch_phase         = STAGE_SECOND;
                            r.first_touch_event = 1'b1;
                        end
                    end else begin
                        first_hits = '0;
                    end
                end
                STAGE_SECOND: begin
                    if (it.touch_active) begin
                        second_hits++;
                        if (second_hits >= 2'd2) begin
                            second_hits          = '0;
                            touch_phase          = STAGE_THIRD;
                            r.second_touch_event = 1'b1;
                        end
                    end else begin
                        second_hits = '0;
                    end
                    second_wait = second_wait + 1'b1;
                    if (second_wait >= cfg_stage) begin
                        touch_phase = STAGE_FIRST;
                        second_hits = '0;
                        first_hits  = '0;
                        second_wait = '0;
                    end
                end
                STAGE_THIRD: begin
                    third_hits = 1'b0;
                    if (it.touch_active) begin
                        burst_one_armed     = 1'b1;
                        burst_two_armed     = 1'b1;
                        touch_alarm_latched = 1'b1;
                    end
                    third_wait = third_wait + 1'b1;
                    if (third_wait >= cfg_stage) clear_touch_stages();
                end
                default: ;
            endcase

            // Count low wire ticks, declare a cut past the limit
            wire_limit = int'(cfg_wire) + 1;
            if (wire_limit > 63) wire_limit = 63;
            if (!it.wire_intact && wire_low_run < wire_limit) begin
                wire_low_run++;
                if (wire_low_run > cfg_wire || wire_low_run >= wire_limit) begin
                    if (wire_low_run > cfg_wire) begin
                        burst_one_armed = 1'b1;
                        burst_two_armed = 1'b1;
                        wire_cut_seen   = 1'b1;
                    end
                    wire_low_run = WIRE_W'(wire_limit);
                end
            end else if (it.wire_intact && !touch_alarm_latched) begin
                wire_low_run    = '0;
                burst_one_armed = 1'b0;
                burst_two_armed = 1'b0;
            end

            // Battery removal with hysteresis
            if (battery_seen < cfg_bat_low) begin
                battery_gone = 1'b1;
            end else if (battery_seen > cfg_bat_high) begin
                battery_gone        = 1'b0;
                battery_alarms_sent = '0;
            end
        end

        // Debounce raise and fall lines
        if (it.position_enable) begin
            if (it.raised_line_low) begin
                raise_filter++;
                if (raise_filter >= DEBOUNCE_HIT) begin
                    raised_now   = 1'b1;
                    fell_now     = 1'b0;
                    raise_filter = 8'(DEBOUNCE_HOLD);
                    if (!tilt_done) tilt_pending = 1'b1;
                end
            end else begin
                raised_now         = 1'b0;
                raised_alarms_sent = '0;
                raise_filter       = '0;
                tilt_pending       = 1'b0;
            end
            if (it.fell_line_low) begin
                fall_filter++;
                if (fall_filter >= DEBOUNCE_HIT) begin
                    fell_now    = 1'b1;
                    raised_now  = 1'b0;
                    fall_filter = 8'(DEBOUNCE_HOLD);
                    if (!tilt_done) tilt_pending = 1'b1;
                end
            end else begin
                fell_now         = 1'b0;
                fell_alarms_sent = '0;
                fall_filter      = '0;
                tilt_pending     = 1'b0;
            end
        end

        // Hold after the first tilt, then drop touch progress
        if (tilt_pending) begin
            tilt_wait = tilt_wait + 1'b1;
            if (tilt_wait >= cfg_tilt) begin
                tilt_pending = 1'b0;
                tilt_wait    = '0;
                tilt_done    = 1'b1;
                clear_touch_stages();
            end
        end

        r.raised_state = raised_now;
        r.fell_state   = fell_now;
        r.theft_active = theft_on;
        return r;
    endfunction

    // Watch both channels and the register port
    always @(posedge i_clk) begin : watch
        t_in_item  tick_in;
        t_out_item seen;
        t_out_item want;
        if (!i_rst_n) begin
            cfg_slow     = RST_SLOW_PERIOD;
            cfg_stage    = RST_STAGE_TIMEOUT;
            cfg_tilt     = RST_TILT_HOLD;
            cfg_wire     = RST_WIRE_CUT;
            cfg_bat_low  = RST_BATTERY_LOW;
            cfg_bat_high = RST_BATTERY_HIGH;
            slow_count          = '0;
            battery_seen        = '0;
            clear_touch_stages();
            burst_one_armed     = 1'b0;
            burst_two_armed     = 1'b0;
            burst_one_sent      = '0;
            burst_two_sent      = '0;
            theft_on            = 1'b0;
            touch_alarm_latched = 1'b0;
            wire_low_run        = '0;
            wire_cut_seen       = 1'b0;
            battery_gone        = 1'b0;
            battery_alarms_sent = '0;
            raise_filter        = '0;
            fall_filter         = '0;
            raised_now          = 1'b0;
            fell_now            = 1'b0;
            raised_alarms_sent  = '0;
            fell_alarms_sent    = '0;
            tilt_pending        = 1'b0;
            tilt_wait           = '0;
            tilt_done           = 1'b0;
            expected_ticks.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SLOW_PERIOD:   cfg_slow     = i_cfg_data;
                    REG_STAGE_TIMEOUT: cfg_stage    = i_cfg_data;
                    REG_TILT_HOLD:     cfg_tilt     = i_cfg_data;
                    REG_WIRE_CUT:      cfg_wire     = i_cfg_data[WIRE_W-1:0];
                    REG_BATTERY_LOW:   cfg_bat_low  = i_cfg_data[BATTERY_W-1:0];
                    REG_BATTERY_HIGH:  cfg_bat_high = i_cfg_data[BATTERY_W-1:0];
                    default: ;
                endcase
            end

            // Compare a result with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                seen.first_touch_event  = i_m_tdata[0];
                seen.second_touch_event = i_m_tdata[1];
                seen.theft_message      = i_m_tdata[3:2];
                seen.theft_speech_one   = i_m_tdata[4];
                seen.theft_speech_two   = i_m_tdata[5];
                seen.battery_alarm      = i_m_tdata[6];
                seen.raised_alarm       = i_m_tdata[7];
                seen.fell_alarm         = i_m_tdata[8];
                seen.raised_state       = i_m_tdata[9];
                seen.fell_state         = i_m_tdata[10];
                seen.theft_active       = i_m_tdata[11];
                if (expected_ticks.size() == 0) begin
                    report_mismatch("unexpected result, tdata", 0, 32'(i_m_tdata));
                end else begin
                    want = expected_ticks.pop_front();
                    if (seen.first_touch_event != want.first_touch_event)
                        report_mismatch("first_touch_event", 32'(want.first_touch_event),
                                        32'(seen.first_touch_event));
                    if (seen.second_touch_event != want.second_touch_event)
                        report_mismatch("second_touch_event", 32'(want.second_touch_event),
                                        32'(seen.second_touch_event));
                    if (seen.theft_message != want.theft_message)
                        report_mismatch("theft_message", 32'(want.theft_message),
                                        32'(seen.theft_message));
                    if (seen.theft_speech_one != want.theft_speech_one)
                        report_mismatch("theft_speech_one", 32'(want.theft_speech_one),
                                        32'(seen.theft_speech_one));
                    if (seen.theft_speech_two != want.theft_speech_two)
                        report_mismatch("theft_speech_two", 32'(want.theft_speech_two),
                                        32'(seen.theft_speech_two));
                    if (seen.battery_alarm != want.battery_alarm)
                        report_mismatch("battery_alarm", 32'(want.battery_alarm),
                                        32'(seen.battery_alarm));
                    if (seen.raised_alarm != want.raised_alarm)
                        report_mismatch("raised_alarm", 32'(want.raised_alarm),
                                        32'(seen.raised_alarm));
                    if (seen.fell_alarm != want.fell_alarm)
                        report_mismatch("fell_alarm", 32'(want.fell_alarm),
                                        32'(seen.fell_alarm));
                    if (seen.raised_state != want.raised_state)
                        report_mismatch("raised_state", 32'(want.raised_state),
                                        32'(seen.raised_state));
                    if (seen.fell_state != want.fell_state)
                        report_mismatch("fell_state", 32'(want.fell_state),
                                        32'(seen.fell_state));
                    if (seen.theft_active != want.theft_active)
                        report_mismatch("theft_active", 32'(want.theft_active),
                                        32'(seen.theft_active));
                end
                results_seen++;
            end

            // Predict the result of each accepted item
            if (i_s_tvalid && i_s_tready) begin
                tick_in.touch_active    = i_s_tdata[0];
                tick_in.raised_line_low = i_s_tdata[1];
                tick_in.fell_line_low   = i_s_tdata[2];
                tick_in.wire_intact     = i_s_tdata[3];
                tick_in.battery_level   = i_s_tdata[13:4];
                tick_in.sensor_enable   = i_s_tdata[14];
                tick_in.position_enable = i_s_tdata[15];
                tick_in.key_on          = i_s_tdata[16];
                expected_ticks.push_back(predict_tick(tick_in));
            end
        end
        o_pending <= expected_ticks.size();
    end

endmodule

FILE: tb/sv/tb_tamper_alarm_tick_controller_top.sv
module tb_tamper_alarm_tick_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tac_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 29;

    typedef enum int {
        KIND_TOUCH,
        KIND_WIRE,
        KIND_TILT,
        KIND_NOISE
    } t_burst_kind;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    int mismatch_count;
    int pending_ticks;
    int cycle_count = 0;
    bit steady      = 1'b0;

    tamper_alarm_tick_controller_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    tac_tick_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tdata        (i_s_axis_tdata),
        .i_s_tvalid       (i_s_axis_tvalid),
        .i_s_tready       (o_s_axis_tready),
        .i_m_tdata        (o_m_axis_tdata),
        .i_m_tvalid       (o_m_axis_tvalid),
        .i_m_tready       (i_m_axis_tready),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_ticks)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at random, never during the steady stretch
    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_in_item tick_of(bit touch, bit raise_low, bit fall_low, bit wire_ok,
                                         logic [BATTERY_W-1:0] battery, bit sens, bit pos,
                                         bit key);
        t_in_item it;
        it.touch_active    = touch;
        it.raised_line_low = raise_low;
        it.fell_line_low   = fall_low;
        it.wire_intact     = wire_ok;
        it.battery_level   = battery;
        it.sensor_enable   = sens;
        it.position_enable = pos;
        it.key_on          = key;
        return it;
    endfunction

    // Offer one item, idling at random first, and hold it until accepted
    task automatic send_tick(input t_in_item it);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, it.key_on, it.position_enable, it.sensor_enable,
                            it.battery_level, it.wire_intact, it.fell_line_low,
                            it.raised_line_low, it.touch_active};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_ticks != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] slow,
                                  input logic [CFG_DATA_W-1:0] stage,
                                  input logic [CFG_DATA_W-1:0] tilt,
                                  input logic [CFG_DATA_W-1:0] wire_cut,
                                  input logic [CFG_DATA_W-1:0] bat_low,
                                  input logic [CFG_DATA_W-1:0] bat_high);
        logic [CFG_IDX_W-1:0]  idx[6];
        logic [CFG_DATA_W-1:0] val[6];
        idx = '{REG_SLOW_PERIOD, REG_STAGE_TIMEOUT, REG_TILT_HOLD,
                REG_WIRE_CUT, REG_BATTERY_LOW, REG_BATTERY_HIGH};
        val = '{slow, stage, tilt, wire_cut, bat_low, bat_high};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in_item             directed[$];
        t_in_item             it;
        t_burst_kind          kind;
        int                   burst_left;
        int                   phase_items;
        int                   low_level;
        int                   pick;
        bit                   tilt_on_fall;
        bit                   key;
        logic [BATTERY_W-1:0] battery;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with short periods so every path shows up quickly
        write_settings(12'd3, 12'd12, 12'd5, 12'd2, 12'h100, 12'h200);
        directed.push_back(tick_of(0, 0, 0, 0, 10'd0, 0, 0, 0));
        directed.push_back(tick_of(1, 1, 1, 1, 10'd1023, 1, 1, 1));
        // two touches, two more, then arm both bursts
        directed.push_back(tick_of(1, 0, 0, 1, 10'd0, 1, 0, 0));
        directed.push_back(tick_of(1, 0, 0, 1, 10'd0, 1, 0, 0));
        directed.push_back(tick_of(1, 0, 0, 1, 10'd0, 1, 0, 0));
        directed.push_back(tick_of(1, 0, 0, 1, 10'd0, 1, 0, 0));
        directed.push_back(tick_of(1, 0, 0, 1, 10'd0, 1, 0, 0));
        directed.push_back(tick_of(0, 0, 0, 1, 10'd0, 1, 0, 0));
        directed.push_back(tick_of(0, 0, 0, 1, 10'd0, 1, 0, 0));
        directed.push_back(tick_of(0, 0, 0, 1, 10'd0, 1, 0, 1));
        directed.push_back(tick_of(0, 0, 0, 1, 10'd0, 1, 0, 1));
        // cut the wire, then let the burst report it
        directed.push_back(tick_of(0, 0, 0, 0, 10'd512, 1, 0, 0));
        directed.push_back(tick_of(0, 0, 0, 0, 10'd512, 1, 0, 0));
        directed.push_back(tick_of(0, 0, 0, 0, 10'd512, 1, 0, 0));
        directed.push_back(tick_of(0, 0, 0, 1, 10'd1023, 1, 0, 0));
        // raise, then fall, each long enough to pass the debounce
        directed.push_back(tick_of(0, 1, 0, 1, 10'd1023, 1, 1, 0));
        directed.push_back(tick_of(0, 1, 0, 1, 10'd1023, 1, 1, 0));
        directed.push_back(tick_of(0, 1, 0, 1, 10'd1023, 1, 1, 0));
        directed.push_back(tick_of(0, 1, 0, 1, 10'd1023, 1, 1, 0));
        directed.push_back(tick_of(0, 0, 1, 1, 10'd700, 1, 1, 0));
        directed.push_back(tick_of(0, 0, 1, 1, 10'd700, 1, 1, 0));
        directed.push_back(tick_of(0, 0, 1, 1, 10'd700, 1, 1, 1));
        directed.push_back(tick_of(0, 0, 1, 1, 10'd700, 0, 1, 0));
        directed.push_back(tick_of(0, 0, 0, 1, 10'd1023, 1, 1, 0));
        directed.push_back(tick_of(0, 0, 0, 1, 10'd1023, 1, 1, 0));
        foreach (directed[n]) send_tick(directed[n]);
        drain();

        // Random phases, each under its own register setting
        burst_left = 0;
        kind       = KIND_NOISE;
        for (int phase = 1; phase <= 9; phase++) begin
            case (phase)
                1: write_settings(12'd1, 12'd1, 12'd1, 12'd1, 12'd0, 12'd0);
                2: write_settings(12'd4095, 12'd4095, 12'd4095, 12'd62, 12'd1023, 12'd1023);
                3: write_settings(RST_SLOW_PERIOD, RST_STAGE_TIMEOUT, RST_TILT_HOLD,
                                  CFG_DATA_W'(RST_WIRE_CUT), CFG_DATA_W'(RST_BATTERY_LOW),
                                  CFG_DATA_W'(RST_BATTERY_HIGH));
                default: begin
                    low_level = $urandom_range(0, 700);
                    write_settings(CFG_DATA_W'($urandom_range(1, 10)),
                                   CFG_DATA_W'($urandom_range(4, 80)),
                                   CFG_DATA_W'($urandom_range(1, 40)),
                                   ($urandom_range(9) == 0) ? 12'd62 :
                                       CFG_DATA_W'($urandom_range(1, 12)),
                                   CFG_DATA_W'(low_level),
                                   CFG_DATA_W'($urandom_range(low_level, 1023)));
                end
            endcase
            phase_items = (phase == 1) ? 150 : (phase <= 3) ? 100 : 175;
            steady = (phase == 5);

            for (int n = 0; n < phase_items; n++) begin
                // Pick a new burst shape when the old one runs out
                if (burst_left == 0) begin
                    pick         = $urandom_range(0, 9);
                    kind         = (pick < 5) ? KIND_TOUCH : (pick < 7) ? KIND_WIRE :
                                   (pick < 9) ? KIND_TILT : KIND_NOISE;
                    burst_left   = $urandom_range(4, 70);
                    tilt_on_fall = 1'($urandom_range(0, 1));
                end
                burst_left--;
                case ($urandom_range(0, 3))
                    0:       battery = '0;
                    1:       battery = '1;
                    default: battery = BATTERY_W'($urandom_range(0, 1023));
                endcase
                key = ($urandom_range(99) < 15);
                case (kind)
                    KIND_TOUCH: it = tick_of($urandom_range(99) < 70, 0, 0,
                                             $urandom_range(99) < 92, battery, 1,
                                             1'($urandom_range(0, 1)), key);
                    KIND_WIRE:  it = tick_of(1'($urandom_range(0, 1)), 0, 0,
                                             $urandom_range(99) < 4, battery, 1,
                                             1'($urandom_range(0, 1)), key);
                    KIND_TILT:  it = tick_of(1'($urandom_range(0, 1)),
                                             !tilt_on_fall && ($urandom_range(99) < 95),
                                             tilt_on_fall && ($urandom_range(99) < 95),
                                             $urandom_range(99) < 90, battery,
                                             1'($urandom_range(0, 1)), 1, key);
                    default:    it = tick_of(1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1)),
                                             battery, 1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1)));
                endcase
                send_tick(it);
            end
            drain();
        end
        steady = 1'b0;

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
